### sv/kbr_pkg.sv
// Package for the basic keyword recognizer: keyword ROM, lengths, widths and
// the result record shared between the step logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package kbr_pkg;

  localparam int unsigned KEYWORD_COUNT    = 14;
  localparam int unsigned MAX_WORD_LETTERS = 10;

  localparam int unsigned ROM_ENTRIES = 14;
  localparam int unsigned ROM_WIDTH   = 6;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

  // One row per keyword, letters in word order, padded with NUL.
  localparam logic [CHAR_W-1:0] KW_ROM [ROM_ENTRIES][ROM_WIDTH] = '{
    '{"P", "R", "I", "N", "T", CHAR_NUL},
    '{"L", "I", "S", "T", CHAR_NUL, CHAR_NUL},
    '{"N", "E", "W", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"R", "U", "N", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"E", "N", "D", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"G", "O", "T", "O", CHAR_NUL, CHAR_NUL},
    '{"F", "O", "R", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"T", "O", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"N", "E", "X", "T", CHAR_NUL, CHAR_NUL},
    '{"G", "O", "S", "U", "B", CHAR_NUL},
    '{"R", "E", "T", "U", "R", "N"},
    '{"D", "I", "M", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"I", "F", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"T", "H", "E", "N", CHAR_NUL, CHAR_NUL}
  };

  localparam logic [COUNT_W-1:0] KW_LEN [ROM_ENTRIES] = '{
    4'd5, 4'd4, 4'd3, 4'd3, 4'd3, 4'd4, 4'd3, 4'd2, 4'd4, 4'd5, 4'd6, 4'd3, 4'd2, 4'd4
  };

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] keyword_index;
    logic [COUNT_W-1:0] word_length;
  } result_t;

endpackage

### sv/basic_keyword_recognizer.sv
// Basic keyword recognizer: one character per cycle, one result per word end.
// Path: a terminating character waits in the input register while a previous result
// is still waiting to be taken; its result is then registered onto the outputs.
// Throughput: one character every cycle. Letters keep flowing while a result waits;
// a terminating character holds the input register until the result register frees.
// Reset: rst_ni clears valids, letter count and too-long flag, and sets all match bits.
// Depends on kbr_pkg and kbr_step.
`timescale 1ns / 1ps

module basic_keyword_recognizer #(
  parameter int unsigned KEYWORD_COUNT    = kbr_pkg::KEYWORD_COUNT,
  parameter int unsigned MAX_WORD_LETTERS = kbr_pkg::MAX_WORD_LETTERS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kbr_pkg::CHAR_W-1:0]  character_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [kbr_pkg::INDEX_W-1:0] keyword_index_o,
  output logic [kbr_pkg::COUNT_W-1:0] word_length_o
);

  logic                        in_valid_q;
  logic [kbr_pkg::CHAR_W-1:0]  char_q;
  logic [kbr_pkg::COUNT_W-1:0] count_q, count_d;
  logic [KEYWORD_COUNT-1:0]    match_q, match_d;
  logic                        too_long_q, too_long_d;
  logic                        out_valid_q;
  kbr_pkg::result_t            result_q, result_d;
  logic                        is_letter;
  logic                        out_free;
  logic                        step_fire;

  kbr_step #(
    .KEYWORD_COUNT   (KEYWORD_COUNT),
    .MAX_WORD_LETTERS(MAX_WORD_LETTERS)
  ) u_step (
    .char_i     (char_q),
    .count_i    (count_q),
    .match_i    (match_q),
    .too_long_i (too_long_q),
    .is_letter_o(is_letter),
    .count_o    (count_d),
    .match_o    (match_d),
    .too_long_o (too_long_d),
    .result_o   (result_d)
  );

  // A letter never needs the result register, so it always moves on.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_fire  = in_valid_q && (is_letter || out_free);
  assign in_stall_o = in_valid_q && !step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      char_q <= character_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      match_q    <= '1;
      too_long_q <= 1'b0;
    end else if (step_fire) begin
      count_q    <= count_d;
      match_q    <= match_d;
      too_long_q <= too_long_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_fire && !is_letter;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step_fire && !is_letter) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = result_q.found;
  assign keyword_index_o = result_q.keyword_index;
  assign word_length_o   = result_q.word_length;

endmodule

### sv/kbr_step.sv
// Combinational step of the keyword recognizer: advances the word state by
// one character and forms the result when the word ends. Uses kbr_pkg.
`timescale 1ns / 1ps

module kbr_step #(
  parameter int unsigned KEYWORD_COUNT    = kbr_pkg::KEYWORD_COUNT,
  parameter int unsigned MAX_WORD_LETTERS = kbr_pkg::MAX_WORD_LETTERS
) (
  input  logic [kbr_pkg::CHAR_W-1:0]  char_i,
  input  logic [kbr_pkg::COUNT_W-1:0] count_i,
  input  logic [KEYWORD_COUNT-1:0]    match_i,
  input  logic                        too_long_i,
  output logic                        is_letter_o,
  output logic [kbr_pkg::COUNT_W-1:0] count_o,
  output logic [KEYWORD_COUNT-1:0]    match_o,
  output logic                        too_long_o,
  output kbr_pkg::result_t            result_o
);

  localparam logic [kbr_pkg::COUNT_W-1:0] MaxLetters = kbr_pkg::COUNT_W'(MAX_WORD_LETTERS);

  logic [KEYWORD_COUNT-1:0] letter_hit;
  logic [KEYWORD_COUNT-1:0] end_hit;

  assign is_letter_o = (char_i >= kbr_pkg::CHAR_A) && (char_i <= kbr_pkg::CHAR_Z);

  // Per-keyword compare of the current letter position and of the length.
  for (genvar k = 0; k < KEYWORD_COUNT; k++) begin : g_kw
    if (k < kbr_pkg::ROM_ENTRIES) begin : g_rom
      logic pos_hit;
      always_comb begin
        pos_hit = 1'b0;
        for (int p = 0; p < kbr_pkg::ROM_WIDTH; p++) begin
          if ((count_i == kbr_pkg::COUNT_W'(p)) && (kbr_pkg::KW_ROM[k][p] == char_i)) begin
            pos_hit = 1'b1;
          end
        end
      end
      assign letter_hit[k] = match_i[k] && pos_hit;
      assign end_hit[k]    = match_i[k] && (kbr_pkg::KW_LEN[k] == count_i);
    end else begin : g_none
      assign letter_hit[k] = 1'b0;
      assign end_hit[k]    = 1'b0;
    end
  end

  always_comb begin
    result_o = '0;
    if (!too_long_i) begin
      // Lowest table position wins.
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
        if (end_hit[k]) begin
          result_o.found         = 1'b1;
          result_o.keyword_index = kbr_pkg::INDEX_W'(k);
          result_o.word_length   = count_i;
        end
      end
    end
  end

  always_comb begin
    if (is_letter_o) begin
      if (count_i >= MaxLetters) begin
        count_o    = MaxLetters;
        match_o    = match_i;
        too_long_o = 1'b1;
      end else begin
        count_o    = count_i + kbr_pkg::COUNT_W'(1);
        match_o    = letter_hit;
        too_long_o = too_long_i;
      end
    end else begin
      count_o    = '0;
      match_o    = '1;
      too_long_o = 1'b0;
    end
  end

endmodule

### sv/kbr_checker.sv
// Port-level checks for the basic keyword recognizer, bound to the top level.
// Depends on kbr_pkg for field widths.
`timescale 1ns / 1ps

module kbr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        found_o,
  input logic [kbr_pkg::INDEX_W-1:0] keyword_index_o,
  input logic [kbr_pkg::COUNT_W-1:0] word_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(found_o) && $stable(keyword_index_o) && $stable(word_length_o))
    else $error("stalled result item changed");

  // The input side only backs up behind a result that is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result item");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (keyword_index_o == '0) && (word_length_o == '0))
    else $error("miss carries nonzero index or length");

  a_hit_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |->
      (word_length_o >= kbr_pkg::COUNT_W'(2)) && (word_length_o <= kbr_pkg::COUNT_W'(6)))
    else $error("found keyword with impossible length");

endmodule

bind basic_keyword_recognizer kbr_checker u_kbr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .keyword_index_o(keyword_index_o),
  .word_length_o  (word_length_o)
);

### tb/kbr_word_checker.sv
// Checker for the basic keyword recognizer: watches both channels, predicts each
// word result from the accepted characters, and compares the results in order.
// Depends on kbr_pkg.
`timescale 1ns / 1ps

module kbr_word_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [kbr_pkg::CHAR_W-1:0]  character_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        found_i,
  input  logic [kbr_pkg::INDEX_W-1:0] keyword_index_i,
  input  logic [kbr_pkg::COUNT_W-1:0] word_length_i,
  output int                          mismatch_count_o,
  output int                          pending_words_o,
  output int                          checked_words_o,
  output int                          keyword_hits_o
);

  logic [kbr_pkg::COUNT_W-1:0]       letters_seen;
  logic [kbr_pkg::KEYWORD_COUNT-1:0] live_keywords;
  logic                              word_overflow;
  kbr_pkg::result_t                  expected_words[$];

  // Advances the word state by one character; a non-letter closes the word.
  task automatic take_character(input logic [kbr_pkg::CHAR_W-1:0] c);
    logic [kbr_pkg::KEYWORD_COUNT-1:0] narrowed;
    kbr_pkg::result_t                  word;
    narrowed = '0;
    word     = '0;
    if (c >= kbr_pkg::CHAR_A && c <= kbr_pkg::CHAR_Z) begin
      if (letters_seen >= kbr_pkg::COUNT_W'(kbr_pkg::MAX_WORD_LETTERS)) begin
        word_overflow = 1'b1;
        letters_seen  = kbr_pkg::COUNT_W'(kbr_pkg::MAX_WORD_LETTERS);
      end else begin
        for (int k = 0; k < kbr_pkg::KEYWORD_COUNT && k < kbr_pkg::ROM_ENTRIES; k++) begin
          if (live_keywords[k] && letters_seen < kbr_pkg::ROM_WIDTH &&
              kbr_pkg::KW_ROM[k][letters_seen] == c) begin
            narrowed[k] = 1'b1;
          end
        end
        live_keywords = narrowed;
        letters_seen  = letters_seen + 1'b1;
      end
    end else begin
      if (!word_overflow) begin
        for (int k = 0; k < kbr_pkg::KEYWORD_COUNT && k < kbr_pkg::ROM_ENTRIES; k++) begin
          if (!word.found && live_keywords[k] && kbr_pkg::KW_LEN[k] == letters_seen) begin
            word.found         = 1'b1;
            word.keyword_index = kbr_pkg::INDEX_W'(k);
            word.word_length   = letters_seen;
          end
        end
      end
      expected_words.push_back(word);
      letters_seen  = '0;
      live_keywords = '1;
      word_overflow = 1'b0;
    end
  endtask

  task automatic report_mismatch(input kbr_pkg::result_t want, input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $write("%0t: %s: expected found=%0b index=%0d length=%0d,",
             $realtime, what, want.found, want.keyword_index, want.word_length);
      $display(" got found=%0b index=%0d length=%0d",
               found_i, keyword_index_i, word_length_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kbr_pkg::result_t want;
    if (!rst_ni) begin
      letters_seen  = '0;
      live_keywords = '1;
      word_overflow = 1'b0;
      expected_words.delete();
      mismatch_count_o = 0;
      checked_words_o  = 0;
      keyword_hits_o   = 0;
    end else begin
      // Compare first: a result never leaves in the cycle its character arrives.
      if (out_valid_i && !out_stall_i) begin
        checked_words_o++;
        if (expected_words.size() == 0) begin
          report_mismatch('0, "result with no word pending");
        end else begin
          want = expected_words.pop_front();
          if (want.found) keyword_hits_o++;
          if (found_i !== want.found || keyword_index_i !== want.keyword_index ||
              word_length_i !== want.word_length) begin
            report_mismatch(want, "word result mismatch");
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_character(character_i);
      end
    end
    pending_words_o = expected_words.size();
  end

endmodule

### tb/basic_keyword_recognizer_test.sv
// Top of the basic keyword recognizer regression: clock, reset, character and
// stall stimulus, and the verdict. Depends on kbr_pkg, the block and kbr_word_checker.
`timescale 1ns / 1ps

module basic_keyword_recognizer_test;

  localparam int CHARACTER_TARGET = 400;
  localparam int HOLD_OFF_CYCLES  = 150;
  localparam int DRAIN_CYCLES     = 10;
  localparam int CYCLE_LIMIT      = 200000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [kbr_pkg::CHAR_W-1:0]  character_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic                        found_o;
  logic [kbr_pkg::INDEX_W-1:0] keyword_index_o;
  logic [kbr_pkg::COUNT_W-1:0] word_length_o;

  int mismatch_count;
  int pending_words;
  int checked_words;
  int keyword_hits;
  int characters_sent;
  int burst_left;

  basic_keyword_recognizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .keyword_index_o(keyword_index_o),
    .word_length_o  (word_length_o)
  );

  kbr_word_checker u_word_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .character_i     (character_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_i         (found_o),
    .keyword_index_i (keyword_index_o),
    .word_length_i   (word_length_o),
    .mismatch_count_o(mismatch_count),
    .pending_words_o (pending_words),
    .checked_words_o (checked_words),
    .keyword_hits_o  (keyword_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout with %0d words still pending", pending_words);
    $display("basic_keyword_recognizer regression: fail");
    $finish;
  end

  // Mostly short gaps, a few long ones, and stretches of back-to-back items.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_character(input logic [kbr_pkg::CHAR_W-1:0] c);
    int gap;
    in_valid_i  <= 1'b1;
    character_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    characters_sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [kbr_pkg::CHAR_W-1:0] random_letter();
    return kbr_pkg::CHAR_A + kbr_pkg::CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [kbr_pkg::CHAR_W-1:0] random_separator();
    logic [kbr_pkg::CHAR_W-1:0] c;
    do c = kbr_pkg::CHAR_W'($urandom_range(0, 255));
    while (c >= kbr_pkg::CHAR_A && c <= kbr_pkg::CHAR_Z);
    return c;
  endfunction

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_character(s[i]);
  endtask

  // One word of random shape followed by a separator, sometimes with extra noise.
  task automatic send_random_word();
    int kind;
    int k;
    int n;
    kind = $urandom_range(0, 99);
    k    = $urandom_range(0, kbr_pkg::ROM_ENTRIES - 1);
    if (kind < 55) begin
      for (int i = 0; i < kbr_pkg::KW_LEN[k]; i++) send_character(kbr_pkg::KW_ROM[k][i]);
      if (kind >= 47) send_character(random_letter());
    end else if (kind < 70) begin
      n = $urandom_range(1, kbr_pkg::KW_LEN[k] - 1);
      for (int i = 0; i < n; i++) send_character(kbr_pkg::KW_ROM[k][i]);
    end else if (kind < 85) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_character(random_letter());
    end else if (kind < 95) begin
      n = $urandom_range(kbr_pkg::MAX_WORD_LETTERS, kbr_pkg::MAX_WORD_LETTERS + 3);
      for (int i = 0; i < n; i++) send_character(random_letter());
    end
    send_character(random_separator());
    if ($urandom_range(0, 9) == 0) send_character(kbr_pkg::CHAR_W'($urandom_range(0, 255)));
  endtask

  // Receiver: one long hold-off right after reset so the block backs up,
  // then random stalls of mixed length.
  initial begin
    int r;
    out_stall_i = 1'b0;
    @(posedge clk_i iff rst_ni);
    out_stall_i <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else if (r < 90) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else if (r < 96) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(30, 60)) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    character_i     = '0;
    characters_sent = 0;
    burst_left      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty words on the byte extremes, letters A and Z against their
    // neighbors, a short keyword, and a word one letter past the maximum.
    send_character(8'h00);
    send_character(8'hFF);
    send_text("IF@");
    send_text("AZ[");
    send_text("GOSUBGOSUBX ");
    send_text("TO");
    send_character(8'hFF);

    while (characters_sent < CHARACTER_TARGET) send_random_word();
    in_valid_i <= 1'b0;

    @(posedge clk_i iff pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d characters, %0d word results checked, %0d keyword hits",
             characters_sent, checked_words, keyword_hits);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("basic_keyword_recognizer regression: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("basic_keyword_recognizer regression: fail");
    end
    $finish;
  end

endmodule
